FILE: src/swnr_pkg.sv
// shared constants and types for the sliding window negative rank filter
package swnr_pkg;

  localparam int MAX_MAGNITUDE = 63;
  localparam int MAX_WINDOW    = 64;

  localparam int SAMPLE_W      = 7;
  localparam int CFG_DATA_W    = 7;
  localparam int CFG_INDEX_W   = 1;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_WINDOW_SIZE = 1'b0,
    REG_RANK        = 1'b1
  } reg_index_t;

  typedef enum logic [7:0] {
    ST_IDLE   = 8'b0000_0001,
    ST_DROP   = 8'b0000_0010,
    ST_DWAIT  = 8'b0000_0100,
    ST_DHWAIT = 8'b0000_1000,
    ST_INS    = 8'b0001_0000,
    ST_INSW   = 8'b0010_0000,
    ST_SRCH   = 8'b0100_0000,
    ST_DONE   = 8'b1000_0000
  } state_t;

endpackage

FILE: src/swnr_ram.sv
// generic single-port-write ram with registered read
module swnr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

FILE: src/sliding_window_negative_rank.sv
// top level of the sliding window negative rank filter
//
// Each transfer on the sample channel takes one signed sample into a delay line held in a
// ram and counts the magnitude of a negative sample in a histogram ram. Once the window
// holds window_size samples, every sample gives one beauty result: the rank-th most negative
// value in the window, with magnitudes clamped to MAX_MAGNITUDE, or 0 when it holds fewer
// than rank negatives. start_req clears the window before its sample is taken in.
// One item is worked on at a time: each old sample dropped (one in steady state, more
// right after window_size shrinks) passes ST_DROP, ST_DWAIT and ST_DHWAIT; when the window
// is full, the search over the histogram ram runs, one bin a cycle from the largest
// magnitude down until rank negatives are counted. A result still waiting in the output
// register holds the next one back. No clearing pass is needed after reset.
module sliding_window_negative_rank
  import swnr_pkg::*;
#(
  parameter int MAX_MAG = MAX_MAGNITUDE,
  parameter int MAX_WIN = MAX_WINDOW
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic                   sample_valid,
  output logic                   sample_stall,
  input  logic signed [SAMPLE_W-1:0] sample,
  input  logic                   start_req,
  output logic                   beauty_valid,
  input  logic                   beauty_stall,
  output logic signed [SAMPLE_W-1:0] beauty
);

  localparam int MAG_W   = $clog2(MAX_MAG + 1);
  localparam int HDEPTH  = MAX_MAG + 1;
  localparam int PTR_W   = (MAX_WIN > 1) ? $clog2(MAX_WIN) : 1;
  localparam int FILL_W  = $clog2(MAX_WIN + 1);
  localparam int SUM_W   = FILL_W + 1;
  localparam int CMP_W   = (SUM_W > CFG_DATA_W) ? SUM_W : CFG_DATA_W;
  localparam int CLAMP_W = (MAG_W > SAMPLE_W) ? MAG_W : SAMPLE_W;
  localparam int WCMP_W  = (FILL_W > CFG_DATA_W) ? FILL_W : CFG_DATA_W;

  // configuration
  logic [CFG_DATA_W-1:0] window_size;
  logic [CFG_DATA_W-1:0] rank;

  // control and working registers
  state_t             state, state_next;
  logic [FILL_W-1:0]  fill;
  logic [PTR_W-1:0]   wp;
  logic [MAG_W-1:0]   mag;
  logic [MAG_W-1:0]   dmag;
  logic [MAG_W-1:0]   sbin;
  logic [MAG_W-1:0]   pbin;
  logic               issuing;
  logic               pvalid;
  logic [FILL_W-1:0]  seen;
  logic [MAG_W-1:0]   res_bin;
  logic [MAG_W-1:0]   hr_addr;
  logic [HDEPTH-1:0]  hvalid;

  // ram ports
  logic               win_we;
  logic [PTR_W-1:0]   win_waddr;
  logic [PTR_W-1:0]   win_raddr;
  logic [MAG_W-1:0]   win_rdata;
  logic               hist_we;
  logic [MAG_W-1:0]   hist_waddr;
  logic [FILL_W-1:0]  hist_wdata;
  logic [MAG_W-1:0]   hist_raddr;
  logic [FILL_W-1:0]  hist_rdata;

  // derived values
  logic               accept;
  logic               out_free;
  logic [SAMPLE_W-1:0] neg_mag;
  logic [CLAMP_W-1:0] mag_full;
  logic [MAG_W-1:0]   mag_in;
  logic [WCMP_W-1:0]  ws_ext;
  logic [FILL_W-1:0]  eff_w;
  logic [CFG_DATA_W-1:0] need;
  logic [FILL_W:0]    pos_full;
  logic [PTR_W-1:0]   drop_pos;
  logic [FILL_W-1:0]  cnt;
  logic [SUM_W-1:0]   sum;
  logic [FILL_W-1:0]  fill_inc;
  logic               drop_needed;
  logic               found;
  logic [CLAMP_W-1:0] neg_bin;

  assign accept       = sample_valid && !sample_stall;
  assign sample_stall = (state != ST_IDLE);
  assign out_free     = !beauty_valid || !beauty_stall;

  // magnitude of a negative sample, clamped
  assign neg_mag  = SAMPLE_W'(~sample) + SAMPLE_W'(1);
  assign mag_full = (CLAMP_W'(neg_mag) > CLAMP_W'(MAX_MAG)) ? CLAMP_W'(MAX_MAG)
                                                            : CLAMP_W'(neg_mag);
  assign mag_in   = sample[SAMPLE_W-1] ? MAG_W'(mag_full) : '0;

  // effective window and rank
  assign ws_ext = WCMP_W'(window_size);
  always_comb begin
    if (window_size == '0) begin
      eff_w = FILL_W'(1);
    end else if (ws_ext > WCMP_W'(MAX_WIN)) begin
      eff_w = FILL_W'(MAX_WIN);
    end else begin
      eff_w = FILL_W'(ws_ext);
    end
  end
  assign need = (rank == '0) ? CFG_DATA_W'(1) : rank;

  // oldest entry of the delay line
  always_comb begin
    if ({1'b0, FILL_W'(wp)} >= {1'b0, fill}) begin
      pos_full = {1'b0, FILL_W'(wp)} - {1'b0, fill};
    end else begin
      pos_full = {1'b0, FILL_W'(wp)} + (FILL_W + 1)'(MAX_WIN) - {1'b0, fill};
    end
  end
  assign drop_pos = (pos_full >= (FILL_W + 1)'(MAX_WIN)) ? '0 : PTR_W'(pos_full);

  assign cnt         = hvalid[hr_addr] ? hist_rdata : '0;
  assign sum         = SUM_W'(seen) + SUM_W'(cnt);
  assign found       = CMP_W'(sum) >= CMP_W'(need);
  assign fill_inc    = fill + FILL_W'(1);
  assign drop_needed = (fill >= eff_w);
  assign neg_bin     = CLAMP_W'(0) - CLAMP_W'(res_bin);

  // ram access
  always_comb begin
    win_we     = 1'b0;
    win_waddr  = wp;
    win_raddr  = drop_pos;
    hist_we    = 1'b0;
    hist_waddr = mag;
    hist_wdata = cnt + FILL_W'(1);
    hist_raddr = sbin;
    case (state)
      ST_DWAIT: begin
        hist_raddr = win_rdata;
      end
      ST_DHWAIT: begin
        hist_waddr = dmag;
        hist_wdata = cnt - FILL_W'(1);
        hist_we    = (dmag != '0) && (cnt != '0);
      end
      ST_INS: begin
        win_we     = 1'b1;
        hist_raddr = mag;
      end
      ST_INSW: begin
        hist_we = (mag != '0);
      end
      default: begin
      end
    endcase
  end

  swnr_ram #(
    .WIDTH (MAG_W),
    .DEPTH (MAX_WIN)
  ) u_window (
    .clk     (clk),
    .wr_en   (win_we),
    .wr_addr (win_waddr),
    .wr_data (mag),
    .rd_addr (win_raddr),
    .rd_data (win_rdata)
  );

  swnr_ram #(
    .WIDTH (FILL_W),
    .DEPTH (HDEPTH)
  ) u_hist (
    .clk     (clk),
    .wr_en   (hist_we),
    .wr_addr (hist_waddr),
    .wr_data (hist_wdata),
    .rd_addr (hist_raddr),
    .rd_data (hist_rdata)
  );

  // sequencer
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = ST_DROP;
        end
      end
      ST_DROP: begin
        state_next = drop_needed ? ST_DWAIT : ST_INS;
      end
      ST_DWAIT: begin
        state_next = ST_DHWAIT;
      end
      ST_DHWAIT: begin
        state_next = ST_DROP;
      end
      ST_INS: begin
        state_next = ST_INSW;
      end
      ST_INSW: begin
        state_next = (fill_inc >= eff_w) ? ST_SRCH : ST_IDLE;
      end
      ST_SRCH: begin
        if (pvalid && (found || pbin == MAG_W'(1))) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      window_size  <= CFG_DATA_W'(1);
      rank         <= CFG_DATA_W'(1);
      fill         <= '0;
      wp           <= '0;
      hvalid       <= '0;
      issuing      <= 1'b0;
      pvalid       <= 1'b0;
      beauty_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_write) begin
        case (reg_index_t'(cfg_index))
          REG_WINDOW_SIZE: window_size <= cfg_data;
          REG_RANK:        rank        <= cfg_data;
          default: begin
          end
        endcase
      end
      if (accept && start_req) begin
        fill   <= '0;
        wp     <= '0;
        hvalid <= '0;
      end
      if (hist_we) begin
        hvalid[hist_waddr] <= 1'b1;
      end
      if (state == ST_DHWAIT) begin
        fill <= fill - FILL_W'(1);
      end
      if (state == ST_INSW) begin
        fill    <= fill_inc;
        wp      <= (wp == PTR_W'(MAX_WIN - 1)) ? '0 : wp + PTR_W'(1);
        issuing <= 1'b1;
        pvalid  <= 1'b0;
      end
      if (state == ST_SRCH) begin
        pvalid <= issuing;
        if (sbin == MAG_W'(1)) begin
          issuing <= 1'b0;
        end
      end
      if (state == ST_DONE && out_free) begin
        beauty_valid <= 1'b1;
      end else if (!beauty_stall) begin
        beauty_valid <= 1'b0;
      end
    end
  end

  // payload and search registers
  always_ff @(posedge clk) begin
    hr_addr <= hist_raddr;
    if (accept) begin
      mag <= mag_in;
    end
    if (state == ST_DWAIT) begin
      dmag <= win_rdata;
    end
    if (state == ST_INSW) begin
      sbin <= MAG_W'(MAX_MAG);
      seen <= '0;
    end
    if (state == ST_SRCH) begin
      pbin <= sbin;
      if (issuing) begin
        sbin <= sbin - MAG_W'(1);
      end
      if (pvalid) begin
        seen <= FILL_W'(sum);
        if (found) begin
          res_bin <= pbin;
        end else if (pbin == MAG_W'(1)) begin
          res_bin <= '0;
        end
      end
    end
    if (state == ST_DONE && out_free) begin
      beauty <= SAMPLE_W'(neg_bin);
    end
  end

  // checks
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= FILL_W'(MAX_WIN))
    else $error("fill count above window capacity");

  a_result_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(beauty_valid) |-> $past(state == ST_DONE))
    else $error("result raised outside the done step");

  a_accept_starts_drop: assert property (@(posedge clk) disable iff (rst)
    accept |=> state == ST_DROP)
    else $error("accepted sample did not enter the drop check");

  a_search_ends: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SRCH && pvalid && pbin == MAG_W'(1)) |=> state == ST_DONE)
    else $error("search ran past the last bin");

endmodule

FILE: dv/swnr_rank_monitor.sv
// channel monitor that predicts and checks beauty transfers of the negative rank filter
module swnr_rank_monitor
  import swnr_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_write,
  input  logic [CFG_INDEX_W-1:0]     cfg_index,
  input  logic [CFG_DATA_W-1:0]      cfg_data,
  input  logic                       sample_valid,
  input  logic                       sample_stall,
  input  logic signed [SAMPLE_W-1:0] sample,
  input  logic                       start_req,
  input  logic                       beauty_valid,
  input  logic                       beauty_stall,
  input  logic signed [SAMPLE_W-1:0] beauty,
  output int                         fail_count,
  output int                         pending
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [CFG_DATA_W-1:0]      win_size_reg;
  logic [CFG_DATA_W-1:0]      rank_reg;
  logic [5:0]                 slot_mag [MAX_WINDOW];
  int                         mag_count [MAX_MAGNITUDE+1];
  int                         fill;
  int                         wr_ptr;
  logic signed [SAMPLE_W-1:0] beauty_q [$];
  logic signed [SAMPLE_W-1:0] want;
  int                         fails = 0;
  int                         waiting = 0;

  assign fail_count = fails;
  assign pending    = waiting;

  task automatic predict_beauty(input logic signed [SAMPLE_W-1:0] s, input logic st);
    int w;
    int mag;
    int pos;
    int need;
    int seen;
    int bin;
    int b;
    w = (win_size_reg == 0) ? 1 : (win_size_reg > MAX_WINDOW) ? MAX_WINDOW : int'(win_size_reg);
    if (st) begin
      foreach (mag_count[i]) mag_count[i] = 0;
      fill   = 0;
      wr_ptr = 0;
    end
    mag = 0;
    if (s < 0) begin
      mag = -int'(s);
      if (mag > MAX_MAGNITUDE) mag = MAX_MAGNITUDE;
    end
    // retire oldest samples until the new one fits
    while (fill >= w) begin
      pos = (wr_ptr + MAX_WINDOW - fill) % MAX_WINDOW;
      if (slot_mag[pos] != 0 && mag_count[slot_mag[pos]] > 0)
        mag_count[slot_mag[pos]]--;
      fill--;
    end
    slot_mag[wr_ptr] = 6'(mag);
    if (mag > 0) mag_count[mag]++;
    wr_ptr = (wr_ptr + 1) % MAX_WINDOW;
    fill++;
    if (fill >= w) begin
      need = (rank_reg == 0) ? 1 : int'(rank_reg);
      seen = 0;
      bin  = 0;
      for (b = MAX_MAGNITUDE; b > 0 && bin == 0; b--) begin
        seen += mag_count[b];
        if (seen >= need) bin = b;
      end
      beauty_q.push_back(SAMPLE_W'(-bin));
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      win_size_reg = CFG_DATA_W'(1);
      rank_reg     = CFG_DATA_W'(1);
      fill         = 0;
      wr_ptr       = 0;
      foreach (mag_count[i]) mag_count[i] = 0;
      beauty_q.delete();
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          REG_WINDOW_SIZE: win_size_reg = cfg_data;
          REG_RANK:        rank_reg     = cfg_data;
          default: ;
        endcase
      end
      if (sample_valid && !sample_stall) predict_beauty(sample, start_req);
      if (beauty_valid && !beauty_stall) begin
        if (beauty_q.size() == 0) begin
          $error("beauty: expected no transfer, actual %0d", beauty);
          fails <= fails + 1;
        end else begin
          want = beauty_q.pop_front();
          if (beauty !== want) begin
            $error("beauty: expected %0d, actual %0d", want, beauty);
            fails <= fails + 1;
          end
        end
      end
    end
    waiting <= beauty_q.size();
  end

endmodule

FILE: dv/sliding_window_negative_rank_test.sv
// stimulus and verdict for the sliding window negative rank filter
module sliding_window_negative_rank_test;
  timeunit 1ns;
  timeprecision 1ps;
  import swnr_pkg::*;

  localparam int CYCLE_LIMIT   = 1000000;
  localparam int SETTLE_CYCLES = 300;
  localparam int HOLD_CYCLES   = 600;
  localparam int NUM_PHASES    = 12;

  logic                       clk = 1'b0;
  logic                       rst;
  logic                       cfg_write;
  logic [CFG_INDEX_W-1:0]     cfg_index;
  logic [CFG_DATA_W-1:0]      cfg_data;
  logic                       sample_valid;
  logic                       sample_stall;
  logic signed [SAMPLE_W-1:0] sample;
  logic                       start_req;
  logic                       beauty_valid;
  logic                       beauty_stall;
  logic signed [SAMPLE_W-1:0] beauty;
  int                         fail_count;
  int                         pending;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  bit hold_req      = 1'b0;
  bit hold_taken    = 1'b0;
  int hold_left     = 0;
  int cycles        = 0;

  int phase_win  [NUM_PHASES] = '{0, 3, 64, 5, 127, 2, 8, 65, 1, 16, 4, 33};
  int phase_rank [NUM_PHASES] = '{0, 2, 64, 1, 127, 1, 3, 40, 1, 9, 0, 20};

  always #4 clk = ~clk;

  sliding_window_negative_rank u_dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .sample       (sample),
    .start_req    (start_req),
    .beauty_valid (beauty_valid),
    .beauty_stall (beauty_stall),
    .beauty       (beauty)
  );

  swnr_rank_monitor u_monitor (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .sample       (sample),
    .start_req    (start_req),
    .beauty_valid (beauty_valid),
    .beauty_stall (beauty_stall),
    .beauty       (beauty),
    .fail_count   (fail_count),
    .pending      (pending)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // receiver side, with one long hold-off on request
  initial begin
    beauty_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req && !hold_taken) begin
        hold_taken = 1'b1;
        hold_left  = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        beauty_stall <= 1'b1;
        hold_left--;
      end else begin
        beauty_stall <= ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  function automatic logic signed [SAMPLE_W-1:0] rand_sample();
    int pick;
    pick = $urandom_range(99);
    if (pick < 8)  return SAMPLE_W'(-64);
    if (pick < 14) return SAMPLE_W'(-63);
    if (pick < 18) return SAMPLE_W'(63);
    if (pick < 22) return SAMPLE_W'(0);
    if (pick < 70) return SAMPLE_W'(-int'($urandom_range(1, 64)));
    return SAMPLE_W'($urandom);
  endfunction

  task automatic send_sample(input logic signed [SAMPLE_W-1:0] s, input logic st);
    bit ok;
    while ($urandom_range(99) < send_idle_pct) begin
      sample_valid <= 1'b0;
      @(negedge clk);
    end
    sample_valid <= 1'b1;
    sample       <= s;
    start_req    <= st;
    do begin
      @(posedge clk);
      ok = !sample_stall;
      @(negedge clk);
    end while (!ok);
  endtask

  task automatic set_config(input int ws, input int rk);
    sample_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= REG_WINDOW_SIZE;
    cfg_data  <= CFG_DATA_W'(ws);
    @(negedge clk);
    cfg_index <= REG_RANK;
    cfg_data  <= CFG_DATA_W'(rk);
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic run_phase(input int ws, input int rk, input bit fresh, input bit hold_off);
    int w;
    int n;
    int left;
    logic st;
    w = (ws == 0) ? 1 : (ws > MAX_WINDOW) ? MAX_WINDOW : ws;
    n = (w >= 32) ? 60 : 25;
    set_config(ws, rk);
    // long receiver hold-off while samples keep coming
    if (hold_off) hold_req = 1'b1;
    left = fresh ? 0 : $urandom_range(1, w + 4);
    for (int i = 0; i < n; i++) begin
      if (left == 0) begin
        st = 1'b1;
        // mostly runs long enough to fill the window, some cut short
        if ($urandom_range(99) < 85) left = w + $urandom_range(0, 2 * w + 4);
        else left = $urandom_range(1, w);
      end else begin
        st = ($urandom_range(99) < 3);
      end
      left--;
      send_sample(rand_sample(), st);
    end
  endtask

  initial begin
    rst          = 1'b1;
    cfg_write    = 1'b0;
    cfg_index    = REG_WINDOW_SIZE;
    cfg_data     = '0;
    sample_valid = 1'b0;
    sample       = '0;
    start_req    = 1'b0;
    repeat (10) @(negedge clk);
    rst <= 1'b0;

    send_idle_pct = 28;
    recv_idle_pct = 80;

    // window of one: every transfer reports its own sample when negative (clamped to -63), else 0
    set_config(1, 1);
    send_sample(-64, 1'b1);
    send_sample(-63, 1'b0);
    send_sample(63, 1'b0);
    send_sample(0, 1'b0);
    send_sample(-1, 1'b0);
    send_sample(1, 1'b0);
    send_sample(-32, 1'b0);

    set_config(4, 2);
    send_sample(-5, 1'b1);
    send_sample(-3, 1'b0);
    send_sample(-10, 1'b0);
    send_sample(7, 1'b0);
    send_sample(-1, 1'b0);
    send_sample(-63, 1'b0);
    send_sample(2, 1'b1);

    // shrink mid-sequence, rank zero
    set_config(2, 0);
    send_sample(-7, 1'b0);
    send_sample(-20, 1'b0);
    send_sample(-64, 1'b0);

    // rank above the negative count
    set_config(3, 5);
    send_sample(-1, 1'b1);
    send_sample(-2, 1'b0);
    send_sample(-3, 1'b0);

    for (int p = 0; p < NUM_PHASES; p++) begin
      if (p == 4) begin
        send_idle_pct = 80;
        recv_idle_pct = 28;
      end else if (p == 8) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      run_phase(phase_win[p], phase_rank[p], p[0] == 1'b0, p == 9);
    end

    sample_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (pending != 0) $error("beauty: %0d expected transfers never arrived", pending);
    if (fail_count == 0 && pending == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
